### rtl/core/wss_pkg.sv
// Package for the weighted structure similarity unit.
// Types, command/status structs and constants shared by all modules; no dependencies.
`default_nettype none
package wss_pkg;

    localparam int MASS_W    = 24;
    localparam int COORD_W   = 32;
    localparam int SUM_W     = 64;
    localparam int MEAS_W    = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int NORM_W    = SQ_W + 1;
    localparam int LO_CHUNK  = 34;
    localparam int PROD_W    = NORM_W + MASS_W;
    localparam int DIV_W     = 2 * SUM_W;
    localparam int CNT_W     = 7;
    localparam int AXES      = 3;
    localparam int SCALE_STEPS = 2;
    localparam int DIV_STEPS   = DIV_W;
    localparam int ROOT_STEPS  = SUM_W / 2;
    localparam int NUM_SHIFT   = 16;
    localparam int RHO_SHIFT   = 18;
    localparam int RMSD_K      = 16;
    localparam int RHO_K       = 32;

    localparam logic [MEAS_W-1:0] MEAS_MAX = '1;

    typedef enum logic {
        MODE_RMSD = 1'b0,
        MODE_RHO  = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SCALE,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT
    } state_t;

    typedef struct packed {
        logic       item_load;
        logic       sq_en;
        logic       scale_en;
        logic       acc_en;
        logic       div_init;
        logic       div_step;
        logic       root_init;
        logic       root_step;
        logic       out_load;
        logic [1:0] step;
    } wss_cmd_t;

    typedef struct packed {
        logic selected;
        logic last;
        logic den_zero;
        logic out_busy;
    } wss_sts_t;

endpackage
`default_nettype wire

### rtl/core/wss_if.sv
// Channel interfaces of the weighted structure similarity unit: item, result, config.
// Depends on wss_pkg for field widths.
`default_nettype none
interface wss_item_if;
    import wss_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MASS_W-1:0]          atom_mass;
    logic signed [COORD_W-1:0]  ref_x;
    logic signed [COORD_W-1:0]  ref_y;
    logic signed [COORD_W-1:0]  ref_z;
    logic signed [COORD_W-1:0]  cmp_x;
    logic signed [COORD_W-1:0]  cmp_y;
    logic signed [COORD_W-1:0]  cmp_z;
    logic                       selected;
    logic                       last_atom;
    modport source (output valid, atom_mass, ref_x, ref_y, ref_z, cmp_x, cmp_y, cmp_z,
                    selected, last_atom, input ready);
    modport sink   (input valid, atom_mass, ref_x, ref_y, ref_z, cmp_x, cmp_y, cmp_z,
                    selected, last_atom, output ready);
endinterface

interface wss_result_if;
    import wss_pkg::*;
    logic              valid;
    logic              ready;
    logic [MEAS_W-1:0] measure;
    logic              invalid;
    logic              saturated;
    modport source (output valid, measure, invalid, saturated, input ready);
    modport sink   (input valid, measure, invalid, saturated, output ready);
endinterface

interface wss_cfg_if;
    logic valid;
    logic ready;
    logic measure_mode;
    modport source (output valid, measure_mode, input ready);
    modport sink   (input valid, measure_mode, output ready);
endinterface
`default_nettype wire

### rtl/core/wss_ctrl.sv
// Controller of the weighted structure similarity unit: sequences square, scale,
// accumulate, divide and root steps. Depends on wss_pkg.
`default_nettype none
module wss_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire wss_pkg::wss_sts_t sts,
    output wss_pkg::wss_cmd_t      cmd
);
    import wss_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold in ST_CHECK or ST_ROOT while an untaken result blocks the output register.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = ST_CHECK;
            end
            ST_SQUARE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(AXES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SCALE_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                cnt_next = '0;
                if (!sts.last)
                    state_next = ST_IDLE;
                else if (sts.den_zero)
                begin
                    if (!sts.out_busy)
                        state_next = ST_IDLE;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT:
                state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (cnt_reg == CNT_W'(ROOT_STEPS))
                begin
                    if (!sts.out_busy)
                        state_next = ST_IDLE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // Selected items take the arithmetic path before the check.
        if (state_reg == ST_IDLE && accept && sts.selected)
            state_next = ST_SQUARE;
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.step = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.item_load = accept;
            end
            ST_SQUARE:    cmd.sq_en    = 1'b1;
            ST_SCALE:     cmd.scale_en = 1'b1;
            ST_ACC:       cmd.acc_en   = 1'b1;
            ST_CHECK:
            begin
                cmd.div_init = sts.last && !sts.den_zero;
                cmd.out_load = sts.last && sts.den_zero && !sts.out_busy;
            end
            ST_DIV:       cmd.div_step  = 1'b1;
            ST_ROOT_INIT: cmd.root_init = 1'b1;
            ST_ROOT:
            begin
                cmd.root_step = (cnt_reg != CNT_W'(ROOT_STEPS));
                cmd.out_load  = (cnt_reg == CNT_W'(ROOT_STEPS)) && !sts.out_busy;
            end
            default:
                cmd = '0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over an untaken result");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> in_ready)
        else $error("block not idle after result");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.sq_en, cmd.scale_en, cmd.acc_en, cmd.div_step, cmd.root_step}))
        else $error("overlapping datapath commands");
endmodule
`default_nettype wire

### rtl/core/wss_datapath.sv
// Datapath of the weighted structure similarity unit: squares, mass scaling,
// saturating sums, restoring divider, integer root, result register. Depends on wss_pkg.
`default_nettype none
module wss_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         mode_wr,
    input  wire logic                         mode_in,
    input  wire logic [wss_pkg::MASS_W-1:0]   atom_mass,
    input  wire logic [wss_pkg::COORD_W-1:0]  ref_x,
    input  wire logic [wss_pkg::COORD_W-1:0]  ref_y,
    input  wire logic [wss_pkg::COORD_W-1:0]  ref_z,
    input  wire logic [wss_pkg::COORD_W-1:0]  cmp_x,
    input  wire logic [wss_pkg::COORD_W-1:0]  cmp_y,
    input  wire logic [wss_pkg::COORD_W-1:0]  cmp_z,
    input  wire logic                         selected,
    input  wire logic                         last_atom,
    input  wire wss_pkg::wss_cmd_t            cmd,
    output wss_pkg::wss_sts_t                 sts,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [wss_pkg::MEAS_W-1:0]        measure,
    output logic                              invalid,
    output logic                              saturated
);
    import wss_pkg::*;

    mode_t               mode_reg;
    logic [MASS_W-1:0]   m_reg;
    logic [COORD_W-1:0]  rx_reg, ry_reg, rz_reg, cx_reg, cy_reg, cz_reg;
    logic                sel_reg, last_reg;
    logic [NORM_W-1:0]   dd_reg, ss_reg;
    logic [PROD_W-1:0]   pd_reg, ps_reg;
    logic [SUM_W-1:0]    num_reg, den_reg;
    logic                ovf_reg;
    logic [DIV_W-1:0]    div_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    n_reg, res_reg, bit_reg;
    logic                ov_reg;
    logic [MEAS_W-1:0]   meas_reg;
    logic                inv_reg, sat_reg;

    logic [COORD_W-1:0]  ra, ca;
    logic [DIFF_W-1:0]   d, s, dmag, smag;
    logic [SQ_W-1:0]     dsq, ssq;
    logic [LO_CHUNK-1:0] dchunk, schunk;
    logic [LO_CHUNK+MASS_W-1:0] dpart, spart;
    logic [SUM_W-1:0]    nterm, dterm;
    logic                nsat, dsat;
    logic [SUM_W:0]      nsum, dsum;
    logic [SUM_W:0]      rem_ext;
    logic                ge;
    logic [SUM_W-1:0]    root_t;

    always_comb
    begin
        case (cmd.step)
            2'd1:    begin ra = ry_reg; ca = cy_reg; end
            2'd2:    begin ra = rz_reg; ca = cz_reg; end
            default: begin ra = rx_reg; ca = cx_reg; end
        endcase
    end

    assign d    = {ra[COORD_W-1], ra} - {ca[COORD_W-1], ca};
    assign s    = {ra[COORD_W-1], ra} + {ca[COORD_W-1], ca};
    assign dmag = d[DIFF_W-1] ? -d : d;
    assign smag = s[DIFF_W-1] ? -s : s;
    assign dsq  = dmag * dmag;
    assign ssq  = smag * smag;

    // Scale the norms by the mass in two chunks: low bits, then high bits.
    assign dchunk = cmd.step[0] ? LO_CHUNK'(dd_reg[NORM_W-1:LO_CHUNK]) : dd_reg[LO_CHUNK-1:0];
    assign schunk = cmd.step[0] ? LO_CHUNK'(ss_reg[NORM_W-1:LO_CHUNK]) : ss_reg[LO_CHUNK-1:0];
    assign dpart  = dchunk * m_reg;
    assign spart  = schunk * m_reg;

    assign nsat  = |pd_reg[PROD_W-1:SUM_W+NUM_SHIFT];
    assign nterm = nsat ? '1 : pd_reg[SUM_W+NUM_SHIFT-1:NUM_SHIFT];
    assign dsat  = (mode_reg == MODE_RHO) && (|ps_reg[PROD_W-1:SUM_W+RHO_SHIFT]);
    assign dterm = (mode_reg == MODE_RHO)
                 ? (dsat ? '1 : ps_reg[SUM_W+RHO_SHIFT-1:RHO_SHIFT])
                 : SUM_W'(m_reg);
    assign nsum  = {1'b0, num_reg} + {1'b0, nterm};
    assign dsum  = {1'b0, den_reg} + {1'b0, dterm};

    assign rem_ext = {rem_reg, div_reg[DIV_W-1]};
    assign ge      = rem_ext >= {1'b0, den_reg};
    assign root_t  = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RMSD;
            num_reg  <= '0;
            den_reg  <= '0;
            ovf_reg  <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (mode_wr)
                mode_reg <= mode_t'(mode_in);
            if (cmd.acc_en)
            begin
                num_reg <= nsum[SUM_W] ? '1 : nsum[SUM_W-1:0];
                den_reg <= dsum[SUM_W] ? '1 : dsum[SUM_W-1:0];
                ovf_reg <= ovf_reg | nsat | dsat | nsum[SUM_W] | dsum[SUM_W];
            end
            else if (cmd.out_load)
            begin
                num_reg <= '0;
                den_reg <= '0;
                ovf_reg <= 1'b0;
            end
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            m_reg    <= atom_mass;
            rx_reg   <= ref_x;
            ry_reg   <= ref_y;
            rz_reg   <= ref_z;
            cx_reg   <= cmp_x;
            cy_reg   <= cmp_y;
            cz_reg   <= cmp_z;
            sel_reg  <= selected;
            last_reg <= last_atom;
            dd_reg   <= '0;
            ss_reg   <= '0;
            pd_reg   <= '0;
            ps_reg   <= '0;
        end
        if (cmd.sq_en)
        begin
            dd_reg <= dd_reg + NORM_W'(dsq);
            ss_reg <= ss_reg + NORM_W'(ssq);
        end
        if (cmd.scale_en)
        begin
            if (cmd.step[0])
            begin
                pd_reg <= pd_reg + {dpart[PROD_W-LO_CHUNK-1:0], {LO_CHUNK{1'b0}}};
                ps_reg <= ps_reg + {spart[PROD_W-LO_CHUNK-1:0], {LO_CHUNK{1'b0}}};
            end
            else
            begin
                pd_reg <= pd_reg + PROD_W'(dpart);
                ps_reg <= ps_reg + PROD_W'(spart);
            end
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            if (mode_reg == MODE_RHO)
                div_reg <= {{(DIV_W-SUM_W-RHO_K){1'b0}}, num_reg, {RHO_K{1'b0}}};
            else
                div_reg <= {{(DIV_W-SUM_W-RMSD_K){1'b0}}, num_reg, {RMSD_K{1'b0}}};
        end
        // Shift quotient bits in at the bottom as the dividend leaves the top.
        if (cmd.div_step)
        begin
            rem_reg <= ge ? SUM_W'(rem_ext - {1'b0, den_reg}) : rem_ext[SUM_W-1:0];
            div_reg <= {div_reg[DIV_W-2:0], ge};
        end
        if (cmd.root_init)
        begin
            n_reg   <= div_reg[SUM_W-1:0];
            res_reg <= '0;
            bit_reg <= {2'b01, {(SUM_W-2){1'b0}}};
        end
        if (cmd.root_step)
        begin
            if (n_reg >= root_t)
            begin
                n_reg   <= n_reg - root_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
                res_reg <= res_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.out_load)
        begin
            inv_reg <= (den_reg == '0);
            sat_reg <= ovf_reg;
            if (den_reg == '0)
                meas_reg <= '0;
            else if ((|div_reg[DIV_W-1:SUM_W]) || (|res_reg[SUM_W-1:MEAS_W]))
                meas_reg <= MEAS_MAX;
            else
                meas_reg <= res_reg[MEAS_W-1:0];
        end
    end

    assign sts.selected = cmd.item_load ? selected : sel_reg;
    assign sts.last     = last_reg;
    assign sts.den_zero = (den_reg == '0);
    assign sts.out_busy = ov_reg && !out_ready;

    assign out_valid = ov_reg;
    assign measure   = meas_reg;
    assign invalid   = inv_reg;
    assign saturated = sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && inv_reg |-> meas_reg == '0)
        else $error("invalid result with nonzero measure");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> num_reg == '0 && den_reg == '0 && !ovf_reg)
        else $error("sums not cleared after result");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.root_step |-> $onehot(bit_reg))
        else $error("root bit lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> den_reg != '0)
        else $error("divide started on zero denominator");
endmodule
`default_nettype wire

### rtl/core/weighted_structure_similarity_unit.sv
// Top level of the weighted structure similarity unit: ties controller and datapath
// to the item, result and config channels. Depends on wss_pkg, wss_if, wss_ctrl, wss_datapath.
// An unselected atom is only checked; a selected one takes 3 squaring steps on
// one pair of 33x33 multipliers, 2 mass-scaling steps, accumulate and check.
// A last atom with a nonzero denominator then takes a 128-step restoring divider,
// root setup, 32 root steps and result load. One item at a time; a finished result waits
// in its output register while the next items are taken. Reset (rst_n low,
// asynchronous) clears sums, flags, mode and control.
`default_nettype none
module weighted_structure_similarity_unit (
    input wire logic   clk,
    input wire logic   rst_n,
    wss_item_if.sink   in_ch,
    wss_result_if.source out_ch,
    wss_cfg_if.sink    cfg
);
    import wss_pkg::*;

    wss_cmd_t cmd;
    wss_sts_t sts;
    logic     cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    wss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wss_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode_wr   (cfg_wr),
        .mode_in   (cfg.measure_mode),
        .atom_mass (in_ch.atom_mass),
        .ref_x     (in_ch.ref_x),
        .ref_y     (in_ch.ref_y),
        .ref_z     (in_ch.ref_z),
        .cmp_x     (in_ch.cmp_x),
        .cmp_y     (in_ch.cmp_y),
        .cmp_z     (in_ch.cmp_z),
        .selected  (in_ch.selected),
        .last_atom (in_ch.last_atom),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .measure   (out_ch.measure),
        .invalid   (out_ch.invalid),
        .saturated (out_ch.saturated)
    );
endmodule
`default_nettype wire
